/* hdl/ppp_pkg.sv */
`default_nettype none
package ppp_pkg;
    localparam int COORD_W = 32;
    localparam int SIZE_W = 13;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;
    // Restoring divider produces this many quotient bits; larger quotients overflow.
    localparam int QB = 33;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd7;

    localparam logic [CFG_W-1:0] ROW_X_LO_RST = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ROW_X_HI_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW_Y_LO_RST = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW_Y_HI_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW_W_LO_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW_W_HI_RST = 64'h0001_0000_0000_0000;
    localparam logic [SIZE_W-1:0] SCREEN_W_RST = 13'd256;
    localparam logic [SIZE_W-1:0] SCREEN_H_RST = 13'd224;

    typedef struct packed {
        logic valid;
        logic kill;
    } ppp_ctrl_t;
endpackage
`default_nettype wire

/* hdl/ppp_point_if.sv */
`default_nettype none
interface ppp_point_if;
    logic valid;
    logic ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    modport source (output valid, output world_x, output world_y, output world_z, input ready);
    modport sink (input valid, input world_x, input world_y, input world_z, output ready);
endinterface
`default_nettype wire

/* hdl/ppp_pixel_if.sv */
`default_nettype none
interface ppp_pixel_if;
    logic valid;
    logic ready;
    logic visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    modport source (output valid, output visible, output screen_x, output screen_y, input ready);
    modport sink (input valid, input visible, input screen_x, input screen_y, output ready);
endinterface
`default_nettype wire

/* hdl/ppp_matrix.sv */
`default_nettype none
module ppp_matrix #(
    parameter int FRAC_BITS = 16,
    localparam int FW = 64 - FRAC_BITS,
    localparam int CW = FW + 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire logic signed [ppp_pkg::COORD_W-1:0] x,
    input  wire logic signed [ppp_pkg::COORD_W-1:0] y,
    input  wire logic signed [ppp_pkg::COORD_W-1:0] z,
    input  wire logic [ppp_pkg::CFG_W-1:0] rows_lo [3],
    input  wire logic [ppp_pkg::CFG_W-1:0] rows_hi [3],
    output logic out_valid,
    output logic signed [CW-1:0] clip [3]
);
    import ppp_pkg::*;

    logic signed [FW-1:0] prod_reg [3][3];
    logic signed [COORD_W-1:0] trans_reg [3];
    logic valid_a_reg;
    logic signed [CW-1:0] clip_reg [3];
    logic valid_b_reg;

    // Stage A: nine products, each floored to FRAC_BITS fraction bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= FW'((64'($signed(rows_lo[r][31:0])) * 64'(x)) >>> FRAC_BITS);
                prod_reg[r][1] <= FW'((64'($signed(rows_lo[r][63:32])) * 64'(y)) >>> FRAC_BITS);
                prod_reg[r][2] <= FW'((64'($signed(rows_hi[r][31:0])) * 64'(z)) >>> FRAC_BITS);
                trans_reg[r] <= $signed(rows_hi[r][63:32]);
            end
        end
    end

    // Stage B: row sums.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                clip_reg[r] <= CW'(prod_reg[r][0]) + CW'(prod_reg[r][1])
                             + CW'(prod_reg[r][2]) + CW'(trans_reg[r]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign clip = clip_reg;
endmodule
`default_nettype wire

/* hdl/ppp_viewport.sv */
`default_nettype none
module ppp_viewport #(
    parameter int FRAC_BITS = 16,
    localparam int CW = 66 - FRAC_BITS,
    localparam int NW = CW + 1
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire ppp_pkg::ppp_ctrl_t in_ctrl,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [CW-1:0] w,
    input  wire logic [ppp_pkg::SIZE_W-1:0] size,
    output logic out_valid,
    output logic out_ok,
    output logic signed [ppp_pkg::COORD_W-1:0] res
);
    import ppp_pkg::*;

    localparam int DW = CW + 1;
    localparam int PRW = NW + SIZE_W;
    localparam int NUMW = PRW + FRAC_BITS;
    localparam int HIW = NUMW - QB;
    localparam int CMPW = (HIW > DW) ? HIW : DW;

    // Stage 1: sign and magnitude, divisor 2w.
    ppp_ctrl_t c1_reg;
    logic neg1_reg;
    logic [NW-1:0] mag1_reg;
    logic [DW-1:0] d1_reg;
    // Stage 2: magnitude times size.
    ppp_ctrl_t c2_reg;
    logic neg2_reg;
    logic [PRW-1:0] prod2_reg;
    logic [DW-1:0] d2_reg;
    // Divider stages; index 0 is loaded from the overflow check.
    ppp_ctrl_t dc_reg [QB+1];
    logic dneg_reg [QB+1];
    logic dovf_reg [QB+1];
    logic [DW-1:0] dd_reg [QB+1];
    logic [DW-1:0] dr_reg [QB+1];
    logic [QB-1:0] dq_reg [QB+1];
    logic [QB-1:0] dlow_reg [QB+1];
    // Output register.
    logic valid_o_reg;
    logic ok_o_reg;
    logic signed [COORD_W-1:0] res_o_reg;

    logic [NUMW-1:0] num_full;
    logic [HIW-1:0] num_hi;
    logic [CMPW-1:0] hi_ext;
    logic [QB:0] qq;
    logic [QB:0] q_lim;
    logic ok_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= num[NW-1];
            mag1_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            d1_reg <= {w, 1'b0};
            neg2_reg <= neg1_reg;
            prod2_reg <= PRW'(mag1_reg) * PRW'(size);
            d2_reg <= d1_reg;
        end
    end

    assign num_full = {prod2_reg, {FRAC_BITS{1'b0}}};
    assign num_hi = num_full[NUMW-1:QB];
    assign hi_ext = CMPW'(num_hi);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dneg_reg[0] <= neg2_reg;
            dovf_reg[0] <= hi_ext >= CMPW'(d2_reg);
            dd_reg[0] <= d2_reg;
            dr_reg[0] <= hi_ext[DW-1:0];
            dq_reg[0] <= '0;
            dlow_reg[0] <= num_full[QB-1:0];
        end
    end

    // One quotient bit per stage; the remainder stays below the divisor.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        logic [DW-1:0] shifted;
        logic take;
        assign shifted = {dr_reg[s][DW-2:0], dlow_reg[s][QB-1]};
        assign take = shifted >= dd_reg[s];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dneg_reg[s+1] <= dneg_reg[s];
                dovf_reg[s+1] <= dovf_reg[s];
                dd_reg[s+1] <= dd_reg[s];
                dr_reg[s+1] <= take ? shifted - dd_reg[s] : shifted;
                dq_reg[s+1] <= {dq_reg[s][QB-2:0], take};
                dlow_reg[s+1] <= {dlow_reg[s][QB-2:0], 1'b0};
            end
        end
    end

    // Negative values round toward minus infinity, so the magnitude rounds up.
    assign qq = {1'b0, dq_reg[QB]} + (QB+1)'(dneg_reg[QB] && (dr_reg[QB] != '0));
    assign q_lim = dneg_reg[QB] ? (QB+1)'(34'h0_8000_0000) : (QB+1)'(34'h0_7FFF_FFFF);
    assign ok_next = !dc_reg[QB].kill && !dovf_reg[QB] && (qq <= q_lim);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_o_reg <= ok_next;
            res_o_reg <= dneg_reg[QB] ? -$signed(qq[COORD_W-1:0]) : $signed(qq[COORD_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            for (int i = 0; i <= QB; i++)
            begin
                dc_reg[i] <= '0;
            end
            valid_o_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_reg <= in_ctrl;
            c2_reg <= c1_reg;
            dc_reg[0] <= c2_reg;
            for (int i = 0; i < QB; i++)
            begin
                dc_reg[i+1] <= dc_reg[i];
            end
            valid_o_reg <= dc_reg[QB].valid;
        end
    end

    assign out_valid = valid_o_reg;
    assign out_ok = ok_o_reg;
    assign res = res_o_reg;
endmodule
`default_nettype wire

/* hdl/perspective_point_projector_top.sv */
// Channel   Direction  Payload
// pt        in         world_x, world_y, world_z (signed fixed point)
// px        out        visible, screen_x, screen_y (signed fixed point)
// cfg_*     in         write enable, register index, 64-bit data
//
// One item per cycle while px is not stalled; an item passes 40 register stages on its way
// to the output register, which include the 33-stage restoring divider of the viewport.
// Reset clears all valid bits and loads the register defaults.
// The whole pipeline holds while a result waits in the output register.
`default_nettype none
module perspective_point_projector_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ppp_point_if.sink pt,
    ppp_pixel_if.source px,
    input  wire logic cfg_we,
    input  wire logic [ppp_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [ppp_pkg::CFG_W-1:0] cfg_data
);
    import ppp_pkg::*;

    localparam int CW = 66 - FRAC_BITS;
    localparam int NW = CW + 1;
    localparam logic signed [CW-1:0] MIN_DEPTH = CW'((((1 << FRAC_BITS) + 5000) / 10000));

    logic [CFG_W-1:0] rows_lo_reg [3];
    logic [CFG_W-1:0] rows_hi_reg [3];
    logic [SIZE_W-1:0] screen_w_reg;
    logic [SIZE_W-1:0] screen_h_reg;

    logic en;
    logic mat_valid;
    logic signed [CW-1:0] clip [3];

    ppp_ctrl_t ctrl_c_reg;
    logic signed [NW-1:0] nx_c_reg;
    logic signed [NW-1:0] ny_c_reg;
    logic signed [CW-1:0] w_c_reg;

    logic vx_valid, vy_valid, vx_ok, vy_ok;
    logic signed [COORD_W-1:0] vx_res, vy_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_lo_reg[0] <= ROW_X_LO_RST;
            rows_hi_reg[0] <= ROW_X_HI_RST;
            rows_lo_reg[1] <= ROW_Y_LO_RST;
            rows_hi_reg[1] <= ROW_Y_HI_RST;
            rows_lo_reg[2] <= ROW_W_LO_RST;
            rows_hi_reg[2] <= ROW_W_HI_RST;
            screen_w_reg <= SCREEN_W_RST;
            screen_h_reg <= SCREEN_H_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ROW_X_LO: rows_lo_reg[0] <= cfg_data;
                REG_ROW_X_HI: rows_hi_reg[0] <= cfg_data;
                REG_ROW_Y_LO: rows_lo_reg[1] <= cfg_data;
                REG_ROW_Y_HI: rows_hi_reg[1] <= cfg_data;
                REG_ROW_W_LO: rows_lo_reg[2] <= cfg_data;
                REG_ROW_W_HI: rows_hi_reg[2] <= cfg_data;
                REG_SCREEN_W: screen_w_reg <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_H: screen_h_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign en = !px.valid || px.ready;
    assign pt.ready = en;

    ppp_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(pt.valid),
        .x(pt.world_x),
        .y(pt.world_y),
        .z(pt.world_z),
        .rows_lo(rows_lo_reg),
        .rows_hi(rows_hi_reg),
        .out_valid(mat_valid),
        .clip(clip)
    );

    // Numerators of the viewport map: w + clip x, and w - clip y for the flip.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_c_reg <= NW'(clip[2]) + NW'(clip[0]);
            ny_c_reg <= NW'(clip[2]) - NW'(clip[1]);
            w_c_reg <= clip[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_c_reg <= '0;
        end
        else if (en)
        begin
            ctrl_c_reg.valid <= mat_valid;
            ctrl_c_reg.kill <= clip[2] <= MIN_DEPTH;
        end
    end

    ppp_viewport #(.FRAC_BITS(FRAC_BITS)) u_vp_x (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_ctrl(ctrl_c_reg),
        .num(nx_c_reg),
        .w(w_c_reg),
        .size(screen_w_reg),
        .out_valid(vx_valid),
        .out_ok(vx_ok),
        .res(vx_res)
    );

    ppp_viewport #(.FRAC_BITS(FRAC_BITS)) u_vp_y (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_ctrl(ctrl_c_reg),
        .num(ny_c_reg),
        .w(w_c_reg),
        .size(screen_h_reg),
        .out_valid(vy_valid),
        .out_ok(vy_ok),
        .res(vy_res)
    );

    assign px.valid = vx_valid && vy_valid;
    assign px.visible = vx_ok && vy_ok;
    assign px.screen_x = px.visible ? vx_res : '0;
    assign px.screen_y = px.visible ? vy_res : '0;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        vx_valid == vy_valid)
        else $error("viewport lanes out of step");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (px.valid && !px.ready) |=> (px.valid && $stable(px.screen_x) && $stable(px.screen_y)))
        else $error("result changed while stalled");

    a_killed_invisible: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctrl_c_reg.valid && ctrl_c_reg.kill) |=> !u_vp_x.c1_reg.kill == 1'b0)
        else $error("near-depth flag lost");
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import ppp_pkg::*;

    typedef struct {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
    } point_t;

    typedef struct {
        logic vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } pixel_t;

    localparam longint NEAR_DEPTH = 7;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    ppp_point_if pt();
    ppp_pixel_if px();

    perspective_point_projector_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .pt(pt.sink),
        .px(px.source),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow copy of the block's registers.
    logic [63:0] mat_reg [0:5];
    logic [12:0] scr_w;
    logic [12:0] scr_h;

    point_t pending_points[$];
    pixel_t expected_pixels[$];
    int mismatches = 0;
    int received = 0;
    int idle_cycles = 0;
    bit steady_flow = 1'b0;

    function automatic longint clip_row(logic [63:0] lo, logic [63:0] hi, point_t p);
        longint acc;
        begin
            acc = (longint'($signed(lo[31:0])) * longint'(p.wx)) >>> 16;
            acc += (longint'($signed(lo[63:32])) * longint'(p.wy)) >>> 16;
            acc += (longint'($signed(hi[31:0])) * longint'(p.wz)) >>> 16;
            acc += longint'($signed(hi[63:32]));
            return acc;
        end
    endfunction

    // Floor of n * size * 2^16 / (2 w); returns 0 when outside 32 bits.
    function automatic bit to_pixel(longint n, logic [12:0] size, longint w,
                                    output logic signed [31:0] res);
        logic [127:0] mag;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] r;
        begin
            mag = (n < 0) ? 128'(-n) : 128'(n);
            mag = (mag * 128'(size)) << 16;
            den = 128'(w) << 1;
            q = mag / den;
            r = mag % den;
            res = '0;
            if (n < 0)
            begin
                if (r != 0)
                    q += 1;
                if (q > 128'h8000_0000)
                    return 1'b0;
                res = -q[31:0];
            end
            else
            begin
                if (q > 128'h7FFF_FFFF)
                    return 1'b0;
                res = q[31:0];
            end
            return 1'b1;
        end
    endfunction

    function automatic pixel_t project_point(point_t p);
        pixel_t o;
        longint cx;
        longint cy;
        longint cw;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        begin
            o = '{1'b0, 32'sd0, 32'sd0};
            cx = clip_row(mat_reg[0], mat_reg[1], p);
            cy = clip_row(mat_reg[2], mat_reg[3], p);
            cw = clip_row(mat_reg[4], mat_reg[5], p);
            if (cw <= NEAR_DEPTH)
                return o;
            if (!to_pixel(cw + cx, scr_w, cw, tx))
                return o;
            if (!to_pixel(cw - cy, scr_h, cw, ty))
                return o;
            o = '{1'b1, tx, ty};
            return o;
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_idx <= idx;
            cfg_data <= val;
            if (idx == REG_SCREEN_W)
                scr_w = val[12:0];
            else if (idx == REG_SCREEN_H)
                scr_h = val[12:0];
            else
                mat_reg[idx] = val;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic add_point(int x, int y, int z);
        point_t p;
        begin
            p.wx = x;
            p.wy = y;
            p.wz = z;
            pending_points.push_back(p);
        end
    endtask

    task automatic drain();
        begin
            wait (pending_points.size() == 0 && !pt.valid && expected_pixels.size() == 0);
            repeat (60) @(posedge clk);
        end
    endtask

    function automatic int rand_span(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Driver: one item per handshake, random gap between items except in steady flow.
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        if (!rst_n)
        begin
            pt.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (pt.valid && pt.ready)
            begin
                p.wx = pt.world_x;
                p.wy = pt.world_y;
                p.wz = pt.world_z;
                expected_pixels.push_back(project_point(p));
            end
            if (!(pt.valid && !pt.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pt.valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    p = pending_points.pop_front();
                    pt.world_x <= p.wx;
                    pt.world_y <= p.wy;
                    pt.world_z <= p.wz;
                    pt.valid <= 1'b1;
                    gap_left = steady_flow ? 0 : $urandom_range(0, 4);
                end
                else
                    pt.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result; one long hold-off fills the pipeline.
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            px.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (px.valid && px.ready)
            begin
                received++;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: vis=%0d x=%h y=%h",
                                 px.visible, px.screen_x, px.screen_y);
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (px.visible !== e.vis || px.screen_x !== e.sx ||
                        px.screen_y !== e.sy)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected vis=%0d x=%h y=%h, got vis=%0d x=%h y=%h",
                                     e.vis, e.sx, e.sy, px.visible, px.screen_x,
                                     px.screen_y);
                    end
                end
                if (received == 300)
                    hold_left = 150;
                else
                    hold_left = steady_flow ? 0 : $urandom_range(0, 4);
                px.ready <= (hold_left == 0);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                px.ready <= (hold_left == 0);
            end
            else
                px.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((pt.valid && pt.ready) || (px.valid && px.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [12:0] sizes [0:5];
        int span;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        pt.valid = 1'b0;
        pt.world_x = '0;
        pt.world_y = '0;
        pt.world_z = '0;
        px.ready = 1'b0;
        mat_reg[0] = ROW_X_LO_RST;
        mat_reg[1] = ROW_X_HI_RST;
        mat_reg[2] = ROW_Y_LO_RST;
        mat_reg[3] = ROW_Y_HI_RST;
        mat_reg[4] = ROW_W_LO_RST;
        mat_reg[5] = ROW_W_HI_RST;
        scr_w = SCREEN_W_RST;
        scr_h = SCREEN_H_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed points under the reset matrix, where w is the constant 1.0, whatever z is.
        add_point(0, 0, 32'h0001_0000);
        add_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        add_point(0, 0, 7);                    // z equals NEAR_DEPTH, but w stays 1.0
        add_point(0, 0, 8);                    // z just past NEAR_DEPTH
        add_point(0, 0, 0);
        add_point(0, 0, 32'h8000_0000);        // most negative z; w stays 1.0
        add_point(32'h7FFF_FFFF, 0, 8);        // overflows in x
        add_point(0, 32'h7FFF_FFFF, 8);        // overflows in y
        add_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'hFFFF_FFFF, 1, 32'h0000_0100);
        add_point(32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000);
        drain();

        // Sizes: zero, largest field value, the nominal maximum and some common values.
        sizes = '{13'd0, 13'd8191, 13'd4096, 13'd1, 13'd640, 13'd480};
        for (int ph = 0; ph < 9; ph++)
        begin
            steady_flow = (ph == 3);
            if (ph == 8)
            begin
                for (int r = 0; r < 6; r++)
                    write_reg(CFG_IDX_W'(r), {$urandom, $urandom});
                write_reg(REG_SCREEN_W, 64'(13'($urandom)));
                write_reg(REG_SCREEN_H, 64'(13'($urandom)));
            end
            else
            begin
                write_reg(REG_ROW_X_LO, {32'(rand_span(1 << 16)), 32'(rand_span(1 << 18))});
                write_reg(REG_ROW_X_HI, {32'(rand_span(1 << 20)), 32'(rand_span(1 << 16))});
                write_reg(REG_ROW_Y_LO, {32'(rand_span(1 << 18)), 32'(rand_span(1 << 16))});
                write_reg(REG_ROW_Y_HI, {32'(rand_span(1 << 20)), 32'(rand_span(1 << 16))});
                write_reg(REG_ROW_W_LO, {32'(rand_span(1 << 12)), 32'(rand_span(1 << 12))});
                write_reg(REG_ROW_W_HI, {32'(rand_span(1 << 19)),
                                         32'((1 << 16) + rand_span(1 << 14))});
                write_reg(REG_SCREEN_W,
                          64'((ph < 6) ? sizes[ph] : 13'($urandom_range(0, 4096))));
                write_reg(REG_SCREEN_H,
                          64'((ph < 6) ? sizes[5 - ph] : 13'($urandom_range(0, 4096))));
            end
            for (int k = 0; k < 120; k++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    span = 1 << $urandom_range(8, 24);
                    add_point(rand_span(span), rand_span(span), $urandom_range(0, span));
                end
                else
                    add_point($urandom, $urandom, $urandom);
            end
            drain();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* files.f */
hdl/ppp_pkg.sv
hdl/ppp_point_if.sv
hdl/ppp_pixel_if.sv
hdl/ppp_matrix.sv
hdl/ppp_viewport.sv
hdl/perspective_point_projector_top.sv
tb/tb.sv
